// ===== hw/rtl/vbd_pkg.sv =====
`timescale 1ns / 1ps

package vbd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int SAMPLE_WIDTH = 16;

  localparam int CH_W       = 4;
  localparam int IDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int THR_W      = 15;
  localparam int HOLD_W     = 8;
  localparam int PEAK_W     = 16;
  localparam int CNT_W      = 16;
  localparam int RISE_W     = SAMPLE_WIDTH + 1;
  localparam int CMP_W      = (RISE_W > PEAK_W + 1) ? RISE_W : PEAK_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(328);
  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_THRESHOLD = 2'd0,
    CFG_HOLDOFF        = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]  rise_threshold;
    logic [HOLD_W-1:0] holdoff_samples;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_WIDTH-1:0] z_position;
  } item_t;

  typedef struct packed {
    logic              bump;
    logic [CH_W-1:0]   bump_channel;
    logic [PEAK_W-1:0] peak_rise;
    logic [CNT_W-1:0]  bumps_so_far;
  } result_t;

endpackage

// ===== hw/rtl/vbd_in_if.sv =====
`timescale 1ns / 1ps

interface vbd_in_if;
  import vbd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [CH_W-1:0]                channel;
  logic signed [SAMPLE_WIDTH-1:0] z_position;

  modport source (output valid, output channel, output z_position, input ready);
  modport sink (input valid, input channel, input z_position, output ready);
endinterface

// ===== hw/rtl/vbd_out_if.sv =====
`timescale 1ns / 1ps

interface vbd_out_if;
  import vbd_pkg::*;

  logic              valid;
  logic              ready;
  logic              bump;
  logic [CH_W-1:0]   bump_channel;
  logic [PEAK_W-1:0] peak_rise;
  logic [CNT_W-1:0]  bumps_so_far;

  modport source (
    output valid, output bump, output bump_channel, output peak_rise,
    output bumps_so_far, input ready
  );
  modport sink (
    input valid, input bump, input bump_channel, input peak_rise,
    input bumps_so_far, output ready
  );
endinterface

// ===== hw/rtl/vbd_cfg_if.sv =====
`timescale 1ns / 1ps

interface vbd_cfg_if;
  import vbd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/vbd_cfg_regs.sv =====
`timescale 1ns / 1ps

module vbd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  vbd_cfg_if.sink       cfg_wr,
  output vbd_pkg::cfg_t cfg_o
);
  import vbd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_RISE_THRESHOLD: cfg_nxt.rise_threshold  = cfg_wr.data[THR_W-1:0];
        CFG_HOLDOFF:        cfg_nxt.holdoff_samples = cfg_wr.data[HOLD_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_threshold  <= THR_RESET;
      cfg_r.holdoff_samples <= HOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

// ===== hw/rtl/vbd_core.sv =====
`timescale 1ns / 1ps

module vbd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire_i,
  input  vbd_pkg::item_t   item_i,
  input  vbd_pkg::cfg_t    cfg_i,
  output vbd_pkg::result_t result_o
);
  import vbd_pkg::*;

  localparam logic signed [CMP_W-1:0] PEAK_MAX_W = CMP_W'({PEAK_W{1'b1}});

  logic signed [SAMPLE_WIDTH-1:0] prev_z_r [NUM_CHANNELS];
  logic                           armed_r  [NUM_CHANNELS];
  logic [PEAK_W-1:0]              peak_r   [NUM_CHANNELS];
  logic [HOLD_W-1:0]              since_r  [NUM_CHANNELS];
  logic                           primed_r [NUM_CHANNELS];
  logic [CNT_W-1:0]               total_r  [NUM_CHANNELS];

  logic [IDX_W-1:0]               idx;
  logic                           in_range;
  logic signed [SAMPLE_WIDTH-1:0] prev_nxt;
  logic                           armed_nxt;
  logic [PEAK_W-1:0]              peak_nxt;
  logic [HOLD_W-1:0]              since_nxt;
  logic                           primed_nxt;
  logic [CNT_W-1:0]               total_nxt;
  logic signed [CMP_W-1:0]        z_w;
  logic signed [CMP_W-1:0]        prev_w;
  logic signed [CMP_W-1:0]        rise;
  logic signed [CMP_W-1:0]        thr_w;
  logic signed [CMP_W-1:0]        half_w;
  logic [PEAK_W-1:0]              rise_sat;

  assign idx      = item_i.channel[IDX_W-1:0];
  assign in_range = {1'b0, item_i.channel} < (CH_W+1)'(NUM_CHANNELS);

  assign z_w      = CMP_W'(item_i.z_position);
  assign prev_w   = CMP_W'(prev_z_r[idx]);
  assign rise     = z_w - prev_w;
  assign thr_w    = $signed(CMP_W'(cfg_i.rise_threshold));
  assign half_w   = $signed(CMP_W'(cfg_i.rise_threshold >> 1));
  assign rise_sat = (rise > PEAK_MAX_W) ? {PEAK_W{1'b1}} : rise[PEAK_W-1:0];

  always_comb begin
    prev_nxt   = item_i.z_position;
    armed_nxt  = armed_r[idx];
    peak_nxt   = peak_r[idx];
    primed_nxt = 1'b1;
    total_nxt  = total_r[idx];
    since_nxt  = (since_r[idx] == {HOLD_W{1'b1}}) ? since_r[idx] : since_r[idx] + 1'b1;

    result_o.bump         = 1'b0;
    result_o.bump_channel = item_i.channel;
    result_o.peak_rise    = '0;

    if (primed_r[idx] && (since_nxt >= cfg_i.holdoff_samples)) begin
      if (rise > thr_w) begin
        armed_nxt = 1'b1;
        if (peak_nxt < rise_sat) begin
          peak_nxt = rise_sat;
        end
      end
      if (!armed_nxt) begin
        peak_nxt = '0;
      end else if (rise < half_w) begin
        result_o.bump      = 1'b1;
        result_o.peak_rise = peak_nxt;
        armed_nxt          = 1'b0;
        peak_nxt           = '0;
        since_nxt          = '0;
        total_nxt          = total_nxt + 1'b1;
      end
    end

    result_o.bumps_so_far = total_nxt;

    if (!in_range) begin
      result_o.bump         = 1'b0;
      result_o.peak_rise    = '0;
      result_o.bumps_so_far = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev_z_r[i] <= '0;
        armed_r[i]  <= 1'b0;
        peak_r[i]   <= '0;
        since_r[i]  <= '0;
        primed_r[i] <= 1'b0;
        total_r[i]  <= '0;
      end
    end else if (fire_i && in_range) begin
      prev_z_r[idx] <= prev_nxt;
      armed_r[idx]  <= armed_nxt;
      peak_r[idx]   <= peak_nxt;
      since_r[idx]  <= since_nxt;
      primed_r[idx] <= primed_nxt;
      total_r[idx]  <= total_nxt;
    end
  end
endmodule

// ===== hw/rtl/vertical_bump_detector.sv =====
`timescale 1ns / 1ps
// An accepted request is held in the input register, its result in the result
// register. Throughput: one request per cycle unless out_res.ready stalls it;
// the per-channel state read-modify-write between them sets that figure.
// Reset (rst_n low, synchronous): both stages empty, all channel state zero,
// rise_threshold 328, holdoff_samples 8.
module vertical_bump_detector (
  input  logic      clk,
  input  logic      rst_n,
  vbd_in_if.sink    in_req,
  vbd_out_if.source out_res,
  vbd_cfg_if.sink   cfg_wr
);
  import vbd_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  cfg_t    cfg;
  result_t result;
  logic    advance;
  logic    in_fire;

  assign advance      = !out_valid_r || out_res.ready;
  assign in_req.ready = !s1_valid_r || advance;
  assign in_fire      = in_req.valid && in_req.ready;

  vbd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg_o  (cfg)
  );

  vbd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (s1_valid_r && advance),
    .item_i   (s1_item_r),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.channel    <= in_req.channel;
      s1_item_r.z_position <= in_req.z_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= result;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.bump         = out_res_r.bump;
  assign out_res.bump_channel = out_res_r.bump_channel;
  assign out_res.peak_rise    = out_res_r.peak_rise;
  assign out_res.bumps_so_far = out_res_r.bumps_so_far;

  a_no_peak_without_bump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.bump |-> out_res_r.peak_rise == '0)
    else $error("peak_rise nonzero without bump");

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted request lost from input stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage changed while stalled");

  a_ready_only_when_space: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> s1_valid_r && out_valid_r)
    else $error("ready low with a free stage");
endmodule
